>>> rtl/abd_pkg.sv
// abd_pkg: shared constants, types and helper functions for the anchor box decoder
// no dependencies; used by abd_exp_unit and anchor_box_decode
`timescale 1ns / 1ps

package abd_pkg;

    // exp table size and fixed pipeline depth of the exp unit
    localparam int ABD_EXP_ENTRIES = 64;
    localparam int ABD_EXP_LAT     = 12;

    // field widths
    localparam int ABD_ARG_W  = 33;   // delta * scale, signed Q.24
    localparam int ABD_U_W    = 28;   // clamped argument shifted to [0, 12], Q.24
    localparam int ABD_EXP_W  = 34;   // exp value, unsigned Q.28
    localparam int ABD_FRAC_W = 28;   // interpolation fraction
    localparam int ABD_FRAC_SH = 26;  // span is 3 << 26

    localparam logic signed [ABD_ARG_W-1:0] ABD_ARG_LO = -33'sd134217728;  // -8.0
    localparam logic signed [ABD_ARG_W-1:0] ABD_ARG_HI = 33'sd67108864;    //  4.0
    localparam logic [ABD_FRAC_W-1:0]       ABD_SPAN   = 28'd201326592;    // 12.0

    localparam logic [15:0] ABD_SCALE_RESET = 16'd4096;

    // configuration register indexes
    typedef enum logic [1:0] {
        CFG_SCALE_CY = 2'd0,
        CFG_SCALE_CX = 2'd1,
        CFG_SCALE_H  = 2'd2,
        CFG_SCALE_W  = 2'd3
    } t_cfg_idx;

    // floor(x / 3) by reciprocal multiply, exact for x below 2^21
    function automatic logic [20:0] abd_div3(input logic [20:0] x);
        logic [42:0] p;
        p = {22'd0, x} * 43'd1398102;
        return p[42:22];
    endfunction

    // saturate to signed 16 bits
    function automatic logic signed [15:0] abd_sat16(input logic signed [25:0] v);
        logic signed [15:0] r;
        if (v > 26'sd32767) begin
            r = 16'sh7fff;
        end else if (v < -26'sd32768) begin
            r = 16'sh8000;
        end else begin
            r = 16'(v);
        end
        return r;
    endfunction

endpackage

>>> rtl/abd_exp_unit.sv
// abd_exp_unit: pipelined exp(delta*scale) with clamp, table lookup and interpolation
// depends on abd_pkg
`timescale 1ns / 1ps

module abd_exp_unit import abd_pkg::*; #(
    parameter int EXP_TABLE_ENTRIES = ABD_EXP_ENTRIES
) (
    input  logic                  i_clk,
    input  logic                  i_en,
    input  logic signed [15:0]    i_delta,
    input  logic [15:0]           i_scale,
    output logic [ABD_EXP_W-1:0]  o_value
);

    localparam int N     = EXP_TABLE_ENTRIES;
    localparam int IDX_W = $clog2(N + 1);
    localparam int POS_W = ABD_U_W + IDX_W;
    localparam int T_W   = POS_W - ABD_FRAC_SH;

    // exp table, built at elaboration: exp(-8 + 12*idx/n) in Q.28
    // taylor series of exp(x/16) with truncated terms, then four squarings
    logic [ABD_EXP_W-1:0] w_rom [0:N];

    for (genvar g = 0; g <= N; g++) begin : g_rom
        localparam longint Z   = (longint'(12 * g - 8 * N) * 64'sd16777216) / longint'(N);
        localparam longint ONE = 64'sd268435456;
        localparam longint T1  = ((ONE * Z) / ONE) / 64'sd1;
        localparam longint T2  = ((T1 * Z) / ONE) / 64'sd2;
        localparam longint T3  = ((T2 * Z) / ONE) / 64'sd3;
        localparam longint T4  = ((T3 * Z) / ONE) / 64'sd4;
        localparam longint T5  = ((T4 * Z) / ONE) / 64'sd5;
        localparam longint T6  = ((T5 * Z) / ONE) / 64'sd6;
        localparam longint T7  = ((T6 * Z) / ONE) / 64'sd7;
        localparam longint T8  = ((T7 * Z) / ONE) / 64'sd8;
        localparam longint T9  = ((T8 * Z) / ONE) / 64'sd9;
        localparam longint T10 = ((T9 * Z) / ONE) / 64'sd10;
        localparam longint T11 = ((T10 * Z) / ONE) / 64'sd11;
        localparam longint T12 = ((T11 * Z) / ONE) / 64'sd12;
        localparam longint T13 = ((T12 * Z) / ONE) / 64'sd13;
        localparam longint T14 = ((T13 * Z) / ONE) / 64'sd14;
        localparam longint S   = ONE + T1 + T2 + T3 + T4 + T5 + T6 + T7 + T8 + T9 + T10
                                 + T11 + T12 + T13 + T14;
        localparam logic [63:0] V0 = 64'(S);
        localparam logic [63:0] V1 = (V0 * V0 + 64'd134217728) >> 28;
        localparam logic [63:0] V2 = (V1 * V1 + 64'd134217728) >> 28;
        localparam logic [63:0] V3 = (V2 * V2 + 64'd134217728) >> 28;
        localparam logic [63:0] V4 = (V3 * V3 + 64'd134217728) >> 28;
        assign w_rom[g] = V4[ABD_EXP_W-1:0];
    end

    logic signed [ABD_ARG_W-1:0] r_arg;
    logic [ABD_U_W-1:0]          r_u;
    logic [POS_W-1:0]            r_pos;
    logic [IDX_W-1:0]            r_q;
    logic [T_W-1:0]              r_t;
    logic [ABD_FRAC_SH-1:0]      r_low;
    logic [IDX_W-1:0]            r_idx;
    logic [ABD_FRAC_W-1:0]       r_frac5;
    logic [ABD_FRAC_W-1:0]       r_frac6;
    logic [ABD_FRAC_W-1:0]       r_frac7;
    logic [ABD_EXP_W-1:0]        r_e_lo;
    logic [ABD_EXP_W-1:0]        r_e_hi;
    logic [ABD_EXP_W-1:0]        r_diff;
    logic [ABD_EXP_W-1:0]        r_base7;
    logic [ABD_EXP_W-1:0]        r_base8;
    logic [ABD_EXP_W-1:0]        r_base9;
    logic [ABD_EXP_W-1:0]        r_base10;
    logic [ABD_EXP_W-1:0]        r_base11;
    logic [61:0]                 r_prod;
    logic [17:0]                 r_qh9;
    logic [17:0]                 r_qh10;
    logic [17:0]                 r_qh11;
    logic [17:0]                 r_ph;
    logic [17:0]                 r_pl;
    logic [19:0]                 r_lo;
    logic [19:0]                 r_ql;
    logic [ABD_EXP_W-1:0]        r_val;

    logic signed [ABD_ARG_W-1:0] w_arg_c;
    logic [ABD_U_W-1:0]          w_u;
    logic [20:0]                 w_q;
    logic [T_W-1:0]              w_rem;
    logic [20:0]                 w_qh;
    logic [17:0]                 w_rh;
    logic [20:0]                 w_ql;
    logic [61:0]                 w_prod;

    always_comb begin
        if (r_arg < ABD_ARG_LO) begin
            w_arg_c = ABD_ARG_LO;
        end else if (r_arg > ABD_ARG_HI) begin
            w_arg_c = ABD_ARG_HI;
        end else begin
            w_arg_c = r_arg;
        end
        w_u    = ABD_U_W'(w_arg_c - ABD_ARG_LO);
        w_q    = abd_div3(21'(r_pos >> ABD_FRAC_SH));
        w_rem  = T_W'(r_t - T_W'(3) * T_W'(r_q));
        w_prod = {28'd0, r_diff} * {34'd0, r_frac7};
        w_qh   = abd_div3({3'd0, r_prod[61:44]});
        w_rh   = 18'(r_ph - 18'(r_qh9 * 18'd3));
        w_ql   = abd_div3({1'b0, r_lo});
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            // argument and clamp
            r_arg <= i_delta * $signed({1'b0, i_scale});
            r_u   <= w_u;
            // table position and split into index and fraction
            r_pos <= POS_W'(r_u) * POS_W'(N);
            r_q   <= IDX_W'(w_q);
            r_t   <= T_W'(r_pos >> ABD_FRAC_SH);
            r_low <= r_pos[ABD_FRAC_SH-1:0];
            if (r_q >= IDX_W'(N)) begin
                r_idx   <= IDX_W'(N - 1);
                r_frac5 <= ABD_SPAN;
            end else begin
                r_idx   <= r_q;
                r_frac5 <= {w_rem[1:0], r_low};
            end
            // table read
            r_e_lo  <= w_rom[r_idx];
            r_e_hi  <= w_rom[r_idx + IDX_W'(1)];
            r_frac6 <= r_frac5;
            // interpolation
            r_diff  <= r_e_hi - r_e_lo;
            r_base7 <= r_e_lo;
            r_frac7 <= r_frac6;
            r_prod  <= w_prod;
            r_base8 <= r_base7;
            // divide by span: shift by 26, then divide by 3 in two digits
            r_qh9   <= w_qh[17:0];
            r_ph    <= r_prod[61:44];
            r_pl    <= r_prod[43:26];
            r_base9 <= r_base8;
            r_lo     <= {w_rh[1:0], r_pl};
            r_qh10   <= r_qh9;
            r_base10 <= r_base9;
            r_ql     <= w_ql[19:0];
            r_qh11   <= r_qh10;
            r_base11 <= r_base10;
            r_val    <= ABD_EXP_W'(36'(r_base11) + {r_qh11, 18'd0} + 36'(r_ql));
        end
    end

    assign o_value = r_val;

endmodule

>>> rtl/anchor_box_decode.sv
// anchor_box_decode: center-size anchor box decoder, Q4.12 in and out; uses abd_pkg, abd_exp_unit
// throughput: one box per cycle; the whole pipeline freezes only while a finished box is stalled
// reset (synchronous, active low) empties the pipeline and sets all four scales to 1.0
// the exp table is constant logic, so no fill or clearing pass follows reset
`timescale 1ns / 1ps

module anchor_box_decode import abd_pkg::*; #(
    parameter int EXP_TABLE_ENTRIES = ABD_EXP_ENTRIES
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // configuration writes
    input  logic               i_cfg_we,
    input  logic [1:0]         i_cfg_idx,
    input  logic [15:0]        i_cfg_data,
    // input channel
    input  logic               i_valid,
    output logic               o_stall,
    input  logic signed [15:0] i_delta_y,
    input  logic signed [15:0] i_delta_x,
    input  logic signed [15:0] i_delta_h,
    input  logic signed [15:0] i_delta_w,
    input  logic signed [15:0] i_anchor_cy,
    input  logic signed [15:0] i_anchor_cx,
    input  logic [14:0]        i_anchor_h,
    input  logic [14:0]        i_anchor_w,
    // output channel
    output logic               o_valid,
    input  logic               i_stall,
    output logic signed [15:0] o_box_ymin,
    output logic signed [15:0] o_box_xmin,
    output logic signed [15:0] o_box_ymax,
    output logic signed [15:0] o_box_xmax
);

    // stage map: 1..12 exp units (centers done at 3), 13 anchor*exp, 14 round, 15 corners
    localparam int LAT = ABD_EXP_LAT + 3;
    localparam int CDL = ABD_EXP_LAT - 1;   // center delay, stage 4 to stage 14
    localparam int ADL = ABD_EXP_LAT;       // anchor size delay, stage 1 to stage 12

    typedef struct packed {
        logic signed [24:0] cy;
        logic signed [24:0] cx;
    } t_ctr;

    typedef struct packed {
        logic [14:0] h;
        logic [14:0] w;
    } t_anc;

    // scale registers, unsigned Q4.12
    logic [15:0] r_scale_cy;
    logic [15:0] r_scale_cx;
    logic [15:0] r_scale_h;
    logic [15:0] r_scale_w;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scale_cy <= ABD_SCALE_RESET;
            r_scale_cx <= ABD_SCALE_RESET;
            r_scale_h  <= ABD_SCALE_RESET;
            r_scale_w  <= ABD_SCALE_RESET;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_SCALE_CY: begin
                    r_scale_cy <= i_cfg_data;
                end
                CFG_SCALE_CX: begin
                    r_scale_cx <= i_cfg_data;
                end
                CFG_SCALE_H: begin
                    r_scale_h <= i_cfg_data;
                end
                CFG_SCALE_W: begin
                    r_scale_w <= i_cfg_data;
                end
                default: begin
                end
            endcase
        end
    end

    // pipeline control: one enable for every stage, valid bits travel alongside
    logic           w_en;
    logic [LAT-1:0] r_vld;

    assign o_stall = r_vld[LAT-1] & i_stall;
    assign w_en    = !o_stall;
    assign o_valid = r_vld[LAT-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[LAT-2:0], i_valid};
        end
    end

    // center path: anchor*delta, then *scale, then round and add anchor center
    logic signed [31:0] r_py1;
    logic signed [31:0] r_px1;
    logic signed [15:0] r_ay1;
    logic signed [15:0] r_ax1;
    logic signed [48:0] r_py2;
    logic signed [48:0] r_px2;
    logic signed [15:0] r_ay2;
    logic signed [15:0] r_ax2;
    logic signed [24:0] r_cy;
    logic signed [24:0] r_cx;
    t_ctr               r_cdl [0:CDL-1];
    t_anc               r_anc [0:ADL-1];

    // half size path
    logic [ABD_EXP_W-1:0] w_ev_h;
    logic [ABD_EXP_W-1:0] w_ev_w;
    logic [48:0]          r_hp;
    logic [48:0]          r_wp;
    logic [20:0]          r_hh;
    logic [20:0]          r_hw;

    // output registers
    logic signed [15:0] r_ymin;
    logic signed [15:0] r_xmin;
    logic signed [15:0] r_ymax;
    logic signed [15:0] r_xmax;

    logic signed [25:0] w_cy;
    logic signed [25:0] w_cx;
    logic signed [25:0] w_hh;
    logic signed [25:0] w_hw;

    always_comb begin
        w_cy = 26'(r_cdl[CDL-1].cy);
        w_cx = 26'(r_cdl[CDL-1].cx);
        w_hh = 26'($signed({1'b0, r_hh}));
        w_hw = 26'($signed({1'b0, r_hw}));
    end

    abd_exp_unit #(
        .EXP_TABLE_ENTRIES (EXP_TABLE_ENTRIES)
    ) u_exp_h (
        .i_clk   (i_clk),
        .i_en    (w_en),
        .i_delta (i_delta_h),
        .i_scale (r_scale_h),
        .o_value (w_ev_h)
    );

    abd_exp_unit #(
        .EXP_TABLE_ENTRIES (EXP_TABLE_ENTRIES)
    ) u_exp_w (
        .i_clk   (i_clk),
        .i_en    (w_en),
        .i_delta (i_delta_w),
        .i_scale (r_scale_w),
        .o_value (w_ev_w)
    );

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            // stage 1
            r_py1 <= $signed({1'b0, i_anchor_h}) * i_delta_y;
            r_px1 <= $signed({1'b0, i_anchor_w}) * i_delta_x;
            r_ay1 <= i_anchor_cy;
            r_ax1 <= i_anchor_cx;
            // stage 2, product exact in Q.36
            r_py2 <= r_py1 * $signed({1'b0, r_scale_cy});
            r_px2 <= r_px1 * $signed({1'b0, r_scale_cx});
            r_ay2 <= r_ay1;
            r_ax2 <= r_ax1;
            // stage 3, round half up to Q.12
            r_cy <= 25'(r_ay2) + 25'((r_py2 + 49'sd8388608) >>> 24);
            r_cx <= 25'(r_ax2) + 25'((r_px2 + 49'sd8388608) >>> 24);
            // centers wait for the half sizes
            r_cdl[0] <= '{cy: r_cy, cx: r_cx};
            for (int k = 1; k < CDL; k++) begin
                r_cdl[k] <= r_cdl[k-1];
            end
            // anchor sizes wait for the exp results
            r_anc[0] <= '{h: i_anchor_h, w: i_anchor_w};
            for (int k = 1; k < ADL; k++) begin
                r_anc[k] <= r_anc[k-1];
            end
            // stage 13, anchor size times exp in Q.40
            r_hp <= 49'(r_anc[ADL-1].h) * 49'(w_ev_h);
            r_wp <= 49'(r_anc[ADL-1].w) * 49'(w_ev_w);
            // stage 14, halve and round half up to Q.12
            r_hh <= 21'((r_hp + 49'd268435456) >> 29);
            r_hw <= 21'((r_wp + 49'd268435456) >> 29);
            // stage 15, corners with saturation
            r_ymin <= abd_sat16(w_cy - w_hh);
            r_xmin <= abd_sat16(w_cx - w_hw);
            r_ymax <= abd_sat16(w_cy + w_hh);
            r_xmax <= abd_sat16(w_cx + w_hw);
        end
    end

    assign o_box_ymin = r_ymin;
    assign o_box_xmin = r_xmin;
    assign o_box_ymax = r_ymax;
    assign o_box_xmax = r_xmax;

`ifndef SYNTH
    // input side backs off only because a finished box is held
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> o_valid)
        else $error("input stalled with no output transaction pending");

    // a frozen pipeline neither drops nor creates transactions
    a_vld_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_en |=> $stable(r_vld))
        else $error("valid line moved while frozen");

    // half sizes are never negative, so edges stay ordered
    a_y_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_box_ymin <= o_box_ymax))
        else $error("ymin above ymax");

    a_x_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_box_xmin <= o_box_xmax))
        else $error("xmin above xmax");
`endif

endmodule
